[hw/rtl/sm3_pkg.sv]
// sm3 hash engine package: constants, types and round functions
package sm3_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned NumCfg = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [31:0] TLow  = 32'h79CC4519;
  localparam logic [31:0] THigh = 32'h7A879D8A;
  localparam logic [7:0]  PadMark = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;

  localparam logic [31:0] IvReset [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [2:0] {
    StIdle,
    StPad,
    StRound,
    StFold,
    StEmit
  } state_e;

  // input word: one message byte with its flags
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        is_last;
    logic [63:0] length_bits;
  } msg_item_t;

  // output word: one digest word with its position
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_out_t;

  // control from sequencer to round unit
  typedef struct packed {
    logic       load;    // copy chaining value into working words
    logic       step;    // run one round
    logic       fold;    // xor working words into chaining value
    logic [5:0] round;
  } rnd_ctrl_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

[hw/rtl/sm3_if.sv]
// valid/ready channel interface
interface sm3_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[hw/rtl/sm3_round.sv]
// sm3 round unit: message expansion window, working words and chaining value
module sm3_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sm3_pkg::rnd_ctrl_t  ctrl_i,
  input  logic                init_i,
  input  logic [31:0]         init_cv_i [8],
  input  logic [31:0]         blk_i [16],
  output logic [31:0]         cv_o [8]
);

  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] cv_q [8];
  logic [31:0] w_new, t_j, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic        hi;

  // one round per cycle, w window slides by one word
  always_comb begin
    hi    = (ctrl_i.round >= 6'd16);
    w_new = sm3_pkg::p1(w_q[0] ^ w_q[7] ^ sm3_pkg::rotl(w_q[13], 5'd15))
            ^ sm3_pkg::rotl(w_q[3], 5'd7) ^ w_q[10];
    t_j   = sm3_pkg::rotl(hi ? sm3_pkg::THigh : sm3_pkg::TLow, ctrl_i.round[4:0]);
    a12   = sm3_pkg::rotl(v_q[0], 5'd12);
    ss1   = sm3_pkg::rotl(a12 + v_q[4] + t_j, 5'd7);
    ss2   = ss1 ^ a12;
    if (hi) begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end else begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end
    tt1 = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2 = gg + v_q[7] + ss1 + w_q[0];
  end

  // working words and expansion window
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      v_q <= cv_q;
      w_q <= blk_i;
    end else if (ctrl_i.step) begin
      v_q[0] <= tt1;
      v_q[1] <= v_q[0];
      v_q[2] <= sm3_pkg::rotl(v_q[1], 5'd9);
      v_q[3] <= v_q[2];
      v_q[4] <= sm3_pkg::p0(tt2);
      v_q[5] <= v_q[4];
      v_q[6] <= sm3_pkg::rotl(v_q[5], 5'd19);
      v_q[7] <= v_q[6];
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  // chaining value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= sm3_pkg::IvReset;
    end else if (init_i) begin
      cv_q <= init_cv_i;
    end else if (ctrl_i.fold) begin
      for (int i = 0; i < 8; i++) cv_q[i] <= cv_q[i] ^ v_q[i];
    end
  end

  assign cv_o = cv_q;

endmodule

[hw/rtl/sm3_hash_engine.sv]
// sm3 hash engine top level: byte packer, sequencer and digest output
//
//   channel  dir  payload                                   handshake
//   in_if    in   data_byte, byte_present, is_last, length  valid/ready
//   out_if   out  digest_word, word_index, last_word         valid/ready
//   cfg      in   chain_init_0..7 by index                   write enable
//
// a byte that does not complete a block is packed without leaving idle; a full
// block runs load, 64 rounds and fold in the shared round unit (one round a cycle).
// a last item adds up to 72 padding bytes one a cycle plus their blocks,
// then eight digest words one a cycle as the sink takes them.
// reset loads the standard initial value; ready is low while busy or emitting.
module sm3_hash_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  sm3_if.sink         in_if,
  sm3_if.source       out_if,
  input  logic        cfg_we_i,
  input  logic [sm3_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [sm3_pkg::WordW-1:0]   cfg_data_i
);

  sm3_pkg::state_e    state_q, state_d;
  sm3_pkg::rnd_ctrl_t ctrl;
  logic [31:0] init_q [8];
  logic [31:0] blk_q [16];
  logic [31:0] cv [8];
  logic [5:0]  pos_q;
  logic [6:0]  cnt_q;
  logic [63:0] len_q;
  logic        open_q, pad_q, fin_q, lenph_q;
  logic        acc, take, push, init_cv;
  logic [7:0]  push_byte, pad_byte;
  logic [2:0]  widx_q;
  logic        full;

  assign acc  = in_if.valid && in_if.ready;
  assign take = acc && (in_if.payload.byte_present || in_if.payload.is_last);
  assign init_cv = take && !open_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= sm3_pkg::IvReset;
    end else if (cfg_we_i) begin
      init_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // padding byte: marker, zeros, then length big-endian
  always_comb begin
    if (!pad_q) pad_byte = sm3_pkg::PadMark;
    else if (lenph_q) pad_byte = len_q[{~pos_q[2:0], 3'b000} +: 8];
    else pad_byte = 8'h00;
  end

  assign push = (state_q == sm3_pkg::StIdle && acc && in_if.payload.byte_present)
                || state_q == sm3_pkg::StPad;
  assign push_byte = (state_q == sm3_pkg::StPad) ? pad_byte : in_if.payload.data_byte;
  assign full = push && pos_q == 6'd63;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sm3_pkg::StIdle: begin
        if (full) state_d = sm3_pkg::StRound;
        else if (take && in_if.payload.is_last) state_d = sm3_pkg::StPad;
      end
      sm3_pkg::StPad: begin
        if (full) state_d = sm3_pkg::StRound;
      end
      sm3_pkg::StRound: begin
        if (cnt_q == 7'd64) state_d = sm3_pkg::StFold;
      end
      sm3_pkg::StFold: begin
        if (!fin_q) state_d = sm3_pkg::StIdle;
        else if (lenph_q) state_d = sm3_pkg::StEmit;
        else state_d = sm3_pkg::StPad;
      end
      sm3_pkg::StEmit: begin
        if (out_if.ready && widx_q == 3'd7) state_d = sm3_pkg::StIdle;
      end
      default: state_d = sm3_pkg::StIdle;
    endcase
  end

  // outputs to round unit and channels
  always_comb begin
    ctrl.load  = (state_q == sm3_pkg::StRound) && cnt_q == 7'd0;
    ctrl.step  = (state_q == sm3_pkg::StRound) && cnt_q != 7'd0;
    ctrl.fold  = (state_q == sm3_pkg::StFold);
    ctrl.round = cnt_q[5:0] - 6'd1;
    in_if.ready = (state_q == sm3_pkg::StIdle);
    out_if.valid = (state_q == sm3_pkg::StEmit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sm3_pkg::StIdle;
      pos_q   <= '0;
      cnt_q   <= '0;
      open_q  <= 1'b0;
      pad_q   <= 1'b0;
      fin_q   <= 1'b0;
      lenph_q <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      if (init_cv) pos_q <= '0;
      if (push) pos_q <= (init_cv ? 6'd0 : pos_q) + 6'd1;
      if (take) open_q <= 1'b1;
      // fin_q: last item seen, padding pending
      if (take && in_if.payload.is_last) fin_q <= 1'b1;
      // pad_q: marker byte already pushed
      if (state_q == sm3_pkg::StPad) pad_q <= 1'b1;
      // lenph_q: padding reached byte 56, length bytes follow
      if (state_q == sm3_pkg::StPad && pos_q == 6'd55) lenph_q <= 1'b1;
      if (state_q == sm3_pkg::StRound) cnt_q <= cnt_q + 7'd1;
      if (state_q == sm3_pkg::StFold) cnt_q <= '0;
      if (state_q == sm3_pkg::StEmit && out_if.ready) begin
        widx_q <= widx_q + 3'd1;
        if (widx_q == 3'd7) begin
          open_q  <= 1'b0;
          pad_q   <= 1'b0;
          fin_q   <= 1'b0;
          lenph_q <= 1'b0;
          cnt_q   <= '0;
        end
      end
    end
  end

  // byte packing and length capture
  always_ff @(posedge clk_i) begin
    if (push) begin
      blk_q[init_cv ? 4'd0 : pos_q[5:2]] <=
        {blk_q[init_cv ? 4'd0 : pos_q[5:2]][23:0], push_byte};
    end
    if (take && in_if.payload.is_last) len_q <= in_if.payload.length_bits;
  end

  sm3_round u_round (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .init_i    (init_cv),
    .init_cv_i (init_q),
    .blk_i     (blk_q),
    .cv_o      (cv)
  );

  assign out_if.payload.digest_word = cv[widx_q];
  assign out_if.payload.word_index  = widx_q;
  assign out_if.payload.last_word   = (widx_q == 3'd7);

endmodule

[hw/rtl/sm3_checker.sv]
// port-level checks for the sm3 hash engine
module sm3_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] word_index,
  input logic last_word
);

  // no input taken while digest words are offered
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready during digest");

  // last flag on word seven only
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last flag");

  // digest words advance by one on each take
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last_word |=> out_valid &&
    word_index == $past(word_index) + 3'd1) else $error("index order");

  // stalled word holds its index
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(word_index))
    else $error("stalled word changed");

endmodule

bind sm3_hash_engine sm3_checker u_sm3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_if.valid),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .word_index (out_if.payload.word_index),
  .last_word  (out_if.payload.last_word)
);
